[hdl/sld_pkg.sv]
// ---------------------------------------------------------------------------
// Serial LED command decoder package
// Shared types, register indexes, command kinds and reset values.
// ---------------------------------------------------------------------------
package sld_pkg;

  localparam int FRAME_DEPTH_DEF = 8;
  localparam int PEEK_BYTES      = 7;
  localparam int CFG_IDX_W       = 3;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_ON    = 3'd0;
  localparam kind_t KIND_OFF   = 3'd1;
  localparam kind_t KIND_COLOR = 3'd2;
  localparam kind_t KIND_LEVEL = 3'd3;
  localparam kind_t KIND_CLOCK = 3'd4;
  localparam kind_t KIND_WAKE  = 3'd5;

  localparam cfg_idx_t REG_STOP  = 3'd0;
  localparam cfg_idx_t REG_ON    = 3'd1;
  localparam cfg_idx_t REG_OFF   = 3'd2;
  localparam cfg_idx_t REG_COLOR = 3'd3;
  localparam cfg_idx_t REG_LEVEL = 3'd4;
  localparam cfg_idx_t REG_CLOCK = 3'd5;
  localparam cfg_idx_t REG_WAKE  = 3'd6;

  localparam byte_t STOP_RST  = 8'd126;
  localparam byte_t ON_RST    = 8'd79;
  localparam byte_t OFF_RST   = 8'd70;
  localparam byte_t COLOR_RST = 8'd67;
  localparam byte_t LEVEL_RST = 8'd66;
  localparam byte_t CLOCK_RST = 8'd84;
  localparam byte_t WAKE_RST  = 8'd65;
  localparam byte_t PCT_RST   = 8'd100;

  typedef struct packed {
    byte_t stop_byte;
    byte_t on_letter;
    byte_t off_letter;
    byte_t color_letter;
    byte_t level_letter;
    byte_t clock_letter;
    byte_t wake_letter;
  } cfg_regs_t;

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t level_now;
    byte_t level_saved;
  } led_state_t;

  typedef struct packed {
    kind_t kind;
    byte_t ack_byte;
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t level_pct;
    byte_t year;
    byte_t month;
    byte_t day;
    byte_t hours;
    byte_t minutes;
    byte_t seconds;
  } result_t;

endpackage

[hdl/sld_byte_if.sv]
// ---------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one serial byte per transaction.
// ---------------------------------------------------------------------------
interface sld_byte_if import sld_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/sld_result_if.sv]
// ---------------------------------------------------------------------------
// Command result channel
// Valid/ready channel carrying one decoded command per transaction.
// ---------------------------------------------------------------------------
interface sld_result_if import sld_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t ack_byte;
  byte_t red;
  byte_t green;
  byte_t blue;
  byte_t level_pct;
  byte_t year;
  byte_t month;
  byte_t day;
  byte_t hours;
  byte_t minutes;
  byte_t seconds;

  modport source (
    output valid, output kind, output ack_byte, output red, output green,
    output blue, output level_pct, output year, output month, output day,
    output hours, output minutes, output seconds, input ready
  );
  modport sink (
    input valid, input kind, input ack_byte, input red, input green,
    input blue, input level_pct, input year, input month, input day,
    input hours, input minutes, input seconds, output ready
  );
endinterface

[hdl/sld_cfg_if.sv]
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface sld_cfg_if import sld_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  byte_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/sld_decode.sv]
// ---------------------------------------------------------------------------
// Frame decoder
// Matches the command letter of a finished frame, updates the LED state
// and builds the result item.
// ---------------------------------------------------------------------------
module sld_decode import sld_pkg::*; (
  input  logic [PEEK_BYTES-1:0][7:0] frame,
  input  cfg_regs_t                  cfg,
  input  led_state_t                 state_cur,
  output logic                       hit,
  output led_state_t                 state_nxt,
  output result_t                    res
);

  always_comb begin
    hit       = 1'b0;
    state_nxt = state_cur;
    res       = '0;
    priority if (frame[0] == cfg.on_letter && frame[1] == 8'd0) begin
      hit                 = 1'b1;
      res.kind            = KIND_ON;
      res.ack_byte        = cfg.on_letter;
      state_nxt.level_now = state_cur.level_saved;
    end else if (frame[0] == cfg.off_letter && frame[1] == 8'd0) begin
      hit                 = 1'b1;
      res.kind            = KIND_OFF;
      res.ack_byte        = cfg.off_letter;
      state_nxt.level_now = 8'd0;
    end else if (frame[0] == cfg.color_letter) begin
      hit             = 1'b1;
      res.kind        = KIND_COLOR;
      res.ack_byte    = cfg.color_letter;
      state_nxt.red   = frame[1];
      state_nxt.green = frame[2];
      state_nxt.blue  = frame[3];
    end else if (frame[0] == cfg.level_letter) begin
      hit                   = 1'b1;
      res.kind              = KIND_LEVEL;
      res.ack_byte          = cfg.level_letter;
      state_nxt.level_now   = frame[1];
      state_nxt.level_saved = frame[1];
    end else if (frame[0] == cfg.clock_letter) begin
      hit          = 1'b1;
      res.kind     = KIND_CLOCK;
      res.ack_byte = cfg.clock_letter;
      res.year     = frame[1];
      res.month    = frame[2];
      res.day      = frame[3];
      res.hours    = frame[4];
      res.minutes  = frame[5];
      res.seconds  = frame[6];
    end else if (frame[0] == cfg.wake_letter) begin
      hit          = 1'b1;
      res.kind     = KIND_WAKE;
      res.ack_byte = cfg.wake_letter;
      res.hours    = frame[1];
      res.minutes  = frame[2];
      res.seconds  = frame[3];
    end else begin
      hit = 1'b0;
    end
    res.red       = state_nxt.red;
    res.green     = state_nxt.green;
    res.blue      = state_nxt.blue;
    res.level_pct = state_nxt.level_now;
  end

endmodule

[hdl/serial_led_command_decoder.sv]
// ---------------------------------------------------------------------------
// Serial LED command decoder
// Collects received bytes into a frame, decodes the command at the end of
// the frame and emits one result per recognized command.
//
//   channel | dir | payload                                   | accept
//   in_ch   | in  | rx_byte                                   | valid & ready
//   out_ch  | out | kind, ack_byte, red..blue, level_pct, time | valid & ready
//   cfg_ch  | in  | index, data                               | valid & ready
//
// One byte per cycle unless in_ch stalls; the decode of a finished frame
// sits between the frame buffer and the result register, so its result
// shows in the cycle after the ending byte is taken. in_ch stalls only
// while a result waits and out_ch is not ready. cfg_ch is always ready.
// rst_n (synchronous) clears the frame, LED state and registers to defaults.
// ---------------------------------------------------------------------------
module serial_led_command_decoder import sld_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sld_byte_if.sink     in_ch,
  sld_result_if.source out_ch,
  sld_cfg_if.sink      cfg_ch
);

  localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_DEPTH);

  cfg_regs_t                     cfg_r, cfg_nxt;
  led_state_t                    state_r, state_nxt, state_dec;
  logic [FRAME_DEPTH-1:0][7:0]   frame_r, frame_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  result_t                       res_r, res_nxt, res_dec;
  logic [PEEK_BYTES-1:0][7:0]    peek;
  logic                          hit;
  logic                          in_take;
  logic                          frame_end;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_take = in_ch.valid && in_ch.ready;
  assign frame_end = (count_r == FULL_CNT) || (in_ch.rx_byte == cfg_r.stop_byte);

  always_comb begin
    for (int i = 0; i < PEEK_BYTES; i++) begin
      peek[i] = frame_r[i];
    end
  end

  sld_decode u_decode (
    .frame     (peek),
    .cfg       (cfg_r),
    .state_cur (state_r),
    .hit       (hit),
    .state_nxt (state_dec),
    .res       (res_dec)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_STOP:  cfg_nxt.stop_byte    = cfg_ch.data;
        REG_ON:    cfg_nxt.on_letter    = cfg_ch.data;
        REG_OFF:   cfg_nxt.off_letter   = cfg_ch.data;
        REG_COLOR: cfg_nxt.color_letter = cfg_ch.data;
        REG_LEVEL: cfg_nxt.level_letter = cfg_ch.data;
        REG_CLOCK: cfg_nxt.clock_letter = cfg_ch.data;
        REG_WAKE:  cfg_nxt.wake_letter  = cfg_ch.data;
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    frame_nxt     = frame_r;
    count_nxt     = count_r;
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_take) begin
      if (frame_end) begin
        frame_nxt = '0;
        count_nxt = '0;
        state_nxt = state_dec;
        if (hit) begin
          res_nxt       = res_dec;
          out_valid_nxt = 1'b1;
        end
      end else begin
        frame_nxt[count_r[IDX_W-1:0]] = in_ch.rx_byte;
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{STOP_RST, ON_RST, OFF_RST, COLOR_RST, LEVEL_RST,
                       CLOCK_RST, WAKE_RST};
      state_r     <= '{8'd0, 8'd0, 8'd0, PCT_RST, PCT_RST};
      frame_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = res_r.kind;
  assign out_ch.ack_byte  = res_r.ack_byte;
  assign out_ch.red       = res_r.red;
  assign out_ch.green     = res_r.green;
  assign out_ch.blue      = res_r.blue;
  assign out_ch.level_pct = res_r.level_pct;
  assign out_ch.year      = res_r.year;
  assign out_ch.month     = res_r.month;
  assign out_ch.day       = res_r.day;
  assign out_ch.hours     = res_r.hours;
  assign out_ch.minutes   = res_r.minutes;
  assign out_ch.seconds   = res_r.seconds;

endmodule

[tb/sld_decode_check.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Serial LED command decoder result checker
// Watches the byte, result and register channels. It keeps its own copy of
// the frame buffer, the LED state and the registers, and decodes every
// finished frame into the expected command. It compares each result
// transaction against the oldest pending command, field by field.
// ---------------------------------------------------------------------------
module sld_decode_check import sld_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sld_byte_if   in_mon,
  sld_result_if out_mon,
  sld_cfg_if    cfg_mon,
  output int    fail_count,
  output int    pending
);

  cfg_regs_t regs;
  byte_t     frame_buf [FRAME_DEPTH];
  int        frame_len;
  byte_t     red_q, green_q, blue_q, pct_now, pct_saved;
  result_t   expected_cmds [$];

  initial fail_count = 0;

  function automatic byte_t frame_byte(input int pos);
    return (pos < FRAME_DEPTH) ? frame_buf[pos] : 8'h00;
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < FRAME_DEPTH; i++) frame_buf[i] = 8'h00;
    frame_len = 0;
  endfunction

  // Decode the stored frame, update the LED state, queue any command.
  function automatic void decode_frame();
    result_t cmd;
    byte_t   b0;
    byte_t   b1;
    bit      hit;
    cmd = '0;
    hit = 1'b1;
    b0  = frame_byte(0);
    b1  = frame_byte(1);
    if (b0 == regs.on_letter && b1 == 8'h00) begin
      cmd.kind     = KIND_ON;
      cmd.ack_byte = regs.on_letter;
      pct_now      = pct_saved;
    end else if (b0 == regs.off_letter && b1 == 8'h00) begin
      cmd.kind     = KIND_OFF;
      cmd.ack_byte = regs.off_letter;
      pct_now      = 8'h00;
    end else if (b0 == regs.color_letter) begin
      cmd.kind     = KIND_COLOR;
      cmd.ack_byte = regs.color_letter;
      red_q        = b1;
      green_q      = frame_byte(2);
      blue_q       = frame_byte(3);
    end else if (b0 == regs.level_letter) begin
      cmd.kind     = KIND_LEVEL;
      cmd.ack_byte = regs.level_letter;
      pct_now      = b1;
      pct_saved    = b1;
    end else if (b0 == regs.clock_letter) begin
      cmd.kind     = KIND_CLOCK;
      cmd.ack_byte = regs.clock_letter;
      cmd.year     = b1;
      cmd.month    = frame_byte(2);
      cmd.day      = frame_byte(3);
      cmd.hours    = frame_byte(4);
      cmd.minutes  = frame_byte(5);
      cmd.seconds  = frame_byte(6);
    end else if (b0 == regs.wake_letter) begin
      cmd.kind     = KIND_WAKE;
      cmd.ack_byte = regs.wake_letter;
      cmd.hours    = b1;
      cmd.minutes  = frame_byte(2);
      cmd.seconds  = frame_byte(3);
    end else begin
      hit = 1'b0;
    end
    clear_frame();
    if (hit) begin
      cmd.red       = red_q;
      cmd.green     = green_q;
      cmd.blue      = blue_q;
      cmd.level_pct = pct_now;
      expected_cmds.push_back(cmd);
    end
  endfunction

  function automatic void take_byte(input byte_t b);
    if (frame_len < FRAME_DEPTH && b != regs.stop_byte) begin
      frame_buf[frame_len] = b;
      frame_len++;
    end else begin
      decode_frame();
    end
  endfunction

  function automatic void write_reg(input cfg_idx_t idx, input byte_t val);
    case (idx)
      REG_STOP:  regs.stop_byte    = val;
      REG_ON:    regs.on_letter    = val;
      REG_OFF:   regs.off_letter   = val;
      REG_COLOR: regs.color_letter = val;
      REG_LEVEL: regs.level_letter = val;
      REG_CLOCK: regs.clock_letter = val;
      REG_WAKE:  regs.wake_letter  = val;
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (expected_cmds.size() == 0) begin
      $display("%0t: result with no command pending, expected none, actual kind %0d ack %0d",
               $time, out_mon.kind, out_mon.ack_byte);
      fail_count++;
      return;
    end
    want = expected_cmds.pop_front();
    check_field("kind",      8'(want.kind), 8'(out_mon.kind));
    check_field("ack_byte",  want.ack_byte,  out_mon.ack_byte);
    check_field("red",       want.red,       out_mon.red);
    check_field("green",     want.green,     out_mon.green);
    check_field("blue",      want.blue,      out_mon.blue);
    check_field("level_pct", want.level_pct, out_mon.level_pct);
    check_field("year",      want.year,      out_mon.year);
    check_field("month",     want.month,     out_mon.month);
    check_field("day",       want.day,       out_mon.day);
    check_field("hours",     want.hours,     out_mon.hours);
    check_field("minutes",   want.minutes,   out_mon.minutes);
    check_field("seconds",   want.seconds,   out_mon.seconds);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs      = '{STOP_RST, ON_RST, OFF_RST, COLOR_RST, LEVEL_RST, CLOCK_RST, WAKE_RST};
      red_q     = 8'h00;
      green_q   = 8'h00;
      blue_q    = 8'h00;
      pct_now   = PCT_RST;
      pct_saved = PCT_RST;
      clear_frame();
      expected_cmds.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) write_reg(cfg_mon.index, cfg_mon.data);
      if (in_mon.valid && in_mon.ready) take_byte(in_mon.rx_byte);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending <= expected_cmds.size();
  end

endmodule

[tb/tb_serial_led_command_decoder.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Serial LED command decoder testbench
// Drives directed frames and then random frames under several register
// settings, with random idling on both channels, two long result stalls and
// pauses for the result queue to drain. The checker decodes every frame on
// its own and reports a failure count for the verdict.
// ---------------------------------------------------------------------------
module tb_serial_led_command_decoder import sld_pkg::*; ();

  localparam int FRAME_DEPTH = FRAME_DEPTH_DEF;
  localparam int HOLD_CYCLES = 120;

  logic clk;
  logic rst_n;

  sld_byte_if   in_ch ();
  sld_result_if out_ch ();
  sld_cfg_if    cfg_ch ();

  int        fail_count;
  int        pending;
  int        bytes_sent = 0;
  bit        no_idle = 1'b0;
  bit        rx_hold_req = 1'b0;
  cfg_regs_t cur_cfg;

  localparam cfg_regs_t RESET_CFG =
    '{STOP_RST, ON_RST, OFF_RST, COLOR_RST, LEVEL_RST, CLOCK_RST, WAKE_RST};
  localparam cfg_regs_t EXTREME_CFG =
    '{8'h00, 8'hFF, 8'h00, 8'h01, 8'hFE, 8'h80, 8'h7F};
  localparam cfg_regs_t SHARED_CFG =
    '{8'hFF, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55};
  localparam cfg_regs_t PAIRED_CFG =
    '{8'hFF, 8'h00, 8'h11, 8'h22, 8'h22, 8'h33, 8'h33};

  byte_t directed [] = '{
    LEVEL_RST, 8'hFF, STOP_RST,
    OFF_RST, STOP_RST,
    ON_RST, 8'h01, STOP_RST,
    ON_RST, STOP_RST,
    COLOR_RST, 8'hFF, 8'h00, STOP_RST,
    STOP_RST,
    CLOCK_RST, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h00,
    WAKE_RST, 8'd23, 8'd59, STOP_RST
  };

  serial_led_command_decoder #(.FRAME_DEPTH(FRAME_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sld_decode_check #(.FRAME_DEPTH(FRAME_DEPTH)) u_decode_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_byte(input byte_t b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and hold until every pending command has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input cfg_regs_t regs);
    cfg_idx_t idx [7];
    byte_t    val [7];
    idx = '{REG_STOP, REG_ON, REG_OFF, REG_COLOR, REG_LEVEL, REG_CLOCK, REG_WAKE};
    val = '{regs.stop_byte, regs.on_letter, regs.off_letter, regs.color_letter,
            regs.level_letter, regs.clock_letter, regs.wake_letter};
    for (int i = 0; i < 7; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    cur_cfg = regs;
  endtask

  function automatic byte_t payload_byte();
    byte_t b;
    b = byte_t'($urandom);
    if (b == cur_cfg.stop_byte) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic send_frame();
    int    sel;
    int    len;
    kind_t cmd;
    byte_t letter;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      cmd = kind_t'($urandom_range(KIND_ON, KIND_WAKE));
      case (cmd)
        KIND_ON:    begin letter = cur_cfg.on_letter;    len = 1; end
        KIND_OFF:   begin letter = cur_cfg.off_letter;   len = 1; end
        KIND_COLOR: begin letter = cur_cfg.color_letter; len = 3; end
        KIND_LEVEL: begin letter = cur_cfg.level_letter; len = 1; end
        KIND_CLOCK: begin letter = cur_cfg.clock_letter; len = 6; end
        default:    begin letter = cur_cfg.wake_letter;  len = 3; end
      endcase
      if ($urandom_range(0, 3) == 0) len = $urandom_range(0, FRAME_DEPTH - 1);
      send_byte(letter);
      for (int i = 0; i < len; i++) begin
        if (i == 0 && (cmd == KIND_ON || cmd == KIND_OFF) && cur_cfg.stop_byte != 8'h00 &&
            $urandom_range(0, 3) != 0) begin
          send_byte(8'h00);
        end else begin
          send_byte(payload_byte());
        end
      end
      if (len == FRAME_DEPTH - 1 && $urandom_range(0, 1) == 0) begin
        send_byte(byte_t'($urandom));
      end else begin
        send_byte(cur_cfg.stop_byte);
      end
    end else if (sel < 85) begin
      repeat (FRAME_DEPTH) send_byte(payload_byte());
      send_byte(byte_t'($urandom));
    end else if (sel < 90) begin
      send_byte(cur_cfg.stop_byte);
    end else begin
      repeat ($urandom_range(1, 10)) send_byte(byte_t'($urandom));
    end
  endtask

  task automatic run_frames(input int upto);
    while (bytes_sent < upto) send_frame();
  endtask

  initial begin : stimulus
    cfg_regs_t rnd_cfg;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_STOP;
    cfg_ch.data   <= 8'h00;
    cur_cfg = RESET_CFG;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);

    // Long result stall while bytes keep coming.
    rx_hold_req = 1'b1;
    run_frames(200);
    no_idle = 1'b1;
    run_frames(280);
    no_idle = 1'b0;
    run_frames(350);
    wait_drained();

    rnd_cfg.stop_byte    = byte_t'($urandom);
    rnd_cfg.on_letter    = byte_t'($urandom);
    rnd_cfg.off_letter   = byte_t'($urandom);
    rnd_cfg.color_letter = byte_t'($urandom);
    rnd_cfg.level_letter = byte_t'($urandom);
    rnd_cfg.clock_letter = byte_t'($urandom);
    rnd_cfg.wake_letter  = byte_t'($urandom);
    write_config(rnd_cfg);
    run_frames(450);
    wait_drained();
    run_frames(550);
    wait_drained();

    write_config(EXTREME_CFG);
    run_frames(620);
    no_idle = 1'b1;
    run_frames(700);
    no_idle = 1'b0;
    wait_drained();

    write_config(SHARED_CFG);
    run_frames(850);
    wait_drained();

    write_config(PAIRED_CFG);
    run_frames(1000);
    wait_drained();

    write_config(RESET_CFG);
    rx_hold_req = 1'b1;
    run_frames(1150);
    wait_drained();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sld_pkg.sv
hdl/sld_byte_if.sv
hdl/sld_result_if.sv
hdl/sld_cfg_if.sv
hdl/sld_decode.sv
hdl/serial_led_command_decoder.sv
tb/sld_decode_check.sv
tb/tb_serial_led_command_decoder.sv
